[hdl/trt_pkg.sv]
// Shared types and constants for the touch report tracker.
// No dependencies; compiled first.
`default_nettype none

package trt_pkg;

  localparam int NUM_EVT = 7;
  localparam int EVT_IDX_W = $clog2(NUM_EVT);
  localparam logic [15:0] JUMP_THR_RESET = 16'd150;

  // fixed result positions within one batch
  localparam int POS_KEY0 = 0;
  localparam int POS_KEY1 = 1;
  localparam int POS_JMP_CONTACT = 2;
  localparam int POS_JMP_SYNC = 3;
  localparam int POS_F0 = 4;
  localparam int POS_F1 = 5;
  localparam int POS_SYNC = 6;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    EV_KEY     = 2'd0,
    EV_CONTACT = 2'd1,
    EV_SYNC    = 2'd2
  } evt_kind_t;

  typedef logic signed [2:0] status_t;

  localparam status_t ST_PRESSED  = 3'sd1;
  localparam status_t ST_RELEASED = 3'sd0;
  localparam status_t ST_IDLE     = -3'sd1;
  localparam status_t ST_FORCED   = -3'sd2;
  localparam status_t ST_STALE    = -3'sd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  key_bits;
    logic [15:0] f0_x;
    logic [15:0] f0_y;
    logic [7:0]  f0_size;
    logic [3:0]  f0_ident;
    logic [15:0] f1_x;
    logic [15:0] f1_y;
    logic [7:0]  f1_size;
    logic [3:0]  f1_ident;
  } item_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic        key_index;
    logic        key_pressed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        touch_major;
    logic [6:0]  width;
  } evt_t;

  typedef struct packed {
    logic [1:0][15:0] x;
    logic [1:0][15:0] y;
    logic [1:0][6:0]  wd;
    logic [1:0][3:0]  id;
    status_t [1:0]    st;
    logic [15:0]      px;
    logic [15:0]      py;
    logic [6:0]       pw;
    logic [3:0]       pid;
    logic [1:0]       keys;
  } state_t;

endpackage

`default_nettype wire

[hdl/trt_in_if.sv]
// Input channel of the touch report tracker: valid/ready plus one request beat.
// No dependencies.
`default_nettype none

interface trt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  key_bits;
  logic [15:0] f0_x;
  logic [15:0] f0_y;
  logic [7:0]  f0_size;
  logic [3:0]  f0_ident;
  logic [15:0] f1_x;
  logic [15:0] f1_y;
  logic [7:0]  f1_size;
  logic [3:0]  f1_ident;

  modport source (
    output valid, req_type, key_bits, f0_x, f0_y, f0_size, f0_ident,
           f1_x, f1_y, f1_size, f1_ident,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_bits, f0_x, f0_y, f0_size, f0_ident,
           f1_x, f1_y, f1_size, f1_ident,
    output ready
  );
endinterface

`default_nettype wire

[hdl/trt_out_if.sv]
// Result channel of the touch report tracker: valid/ready plus one event beat.
// No dependencies.
`default_nettype none

interface trt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic        key_index;
  logic        key_pressed;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        touch_major;
  logic [6:0]  width;
  logic        last;

  modport source (
    output valid, event_kind, key_index, key_pressed, pos_x, pos_y,
           touch_major, width, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, key_index, key_pressed, pos_x, pos_y,
           touch_major, width, last,
    output ready
  );
endinterface

`default_nettype wire

[hdl/trt_eval.sv]
// Combinational evaluation of one request: next tracker state and the batch of
// events at fixed positions with a presence mask. Depends on trt_pkg.
`default_nettype none

module trt_eval
  import trt_pkg::*;
(
  input  item_t                    item,
  input  state_t                   cur,
  input  logic [15:0]              thr,
  output state_t                   nxt,
  output evt_t [NUM_EVT-1:0]       evt,
  output logic [NUM_EVT-1:0]       mask
);

  function automatic status_t hold_st(input status_t s);
    return (s != ST_FORCED) ? ST_PRESSED : ST_FORCED;
  endfunction

  function automatic status_t decay_st(input status_t s);
    status_t r;
    r = s;
    if (s == ST_PRESSED || s == ST_STALE) begin
      r = ST_RELEASED;
    end else if (s == ST_RELEASED || s == ST_FORCED) begin
      r = ST_IDLE;
    end
    return r;
  endfunction

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic evt_t contact(input logic [15:0] x, input logic [15:0] y,
                                   input logic tm, input logic [6:0] w);
    evt_t e;
    e = '0;
    e.kind = EV_CONTACT;
    e.pos_x = x;
    e.pos_y = y;
    e.touch_major = tm;
    e.width = w;
    return e;
  endfunction

  evt_t sync_ev;
  logic jump;
  logic keys_open;

  always_comb begin
    sync_ev = '0;
    sync_ev.kind = EV_SYNC;
  end

  always_comb begin
    nxt = cur;
    evt = '0;
    mask = '0;
    jump = 1'b0;
    keys_open = 1'b0;
    case (req_t'(item.req_type))
      REQ_CLEAR: begin
        nxt.keys = 2'b00;
      end
      REQ_RELEASE: begin
        for (int i = 0; i < 2; i++) begin
          if (cur.id[i] != 4'd0) begin
            nxt.st[i] = ST_FORCED;
          end
          if (nxt.st[i] == ST_FORCED) begin
            mask[POS_F0 + i] = 1'b1;
            evt[POS_F0 + i] = contact(cur.x[i], cur.y[i], 1'b0, cur.wd[i]);
          end
        end
        if (mask[POS_F1:POS_F0] != 2'b00) begin
          mask[POS_SYNC] = 1'b1;
          evt[POS_SYNC] = sync_ev;
        end
      end
      REQ_FRAME: begin
        nxt.x[0] = item.f0_x;
        nxt.y[0] = item.f0_y;
        nxt.wd[0] = item.f0_size[7:1];
        nxt.id[0] = item.f0_ident;
        nxt.x[1] = item.f1_x;
        nxt.y[1] = item.f1_y;
        nxt.wd[1] = item.f1_size[7:1];
        nxt.id[1] = item.f1_ident;

        // key edges only while no finger is held
        keys_open = (cur.st[0] != ST_PRESSED) && (cur.st[1] != ST_PRESSED);
        if (keys_open) begin
          nxt.keys = item.key_bits;
          for (int i = 0; i < 2; i++) begin
            if (item.key_bits[i] != cur.keys[i]) begin
              mask[POS_KEY0 + i] = 1'b1;
              evt[POS_KEY0 + i].kind = EV_KEY;
              evt[POS_KEY0 + i].key_index = 1'(i);
              evt[POS_KEY0 + i].key_pressed = item.key_bits[i];
            end
          end
        end

        // finger 0, with jump check against the prior record
        if (item.f0_ident != 4'd0) begin
          if (cur.st[1] != ST_PRESSED && cur.pid != 4'd0) begin
            jump = (cur.pid != item.f0_ident) ||
                   (abs_diff(cur.px, item.f0_x) > thr) ||
                   (abs_diff(cur.py, item.f0_y) > thr);
            if (jump) begin
              mask[POS_JMP_CONTACT] = 1'b1;
              evt[POS_JMP_CONTACT] = contact(cur.px, cur.py, 1'b0, cur.pw);
              mask[POS_JMP_SYNC] = 1'b1;
              evt[POS_JMP_SYNC] = sync_ev;
              nxt.st[1] = ST_IDLE;
            end else begin
              nxt.st[0] = hold_st(cur.st[0]);
            end
          end else begin
            nxt.st[0] = hold_st(cur.st[0]);
          end
        end else begin
          nxt.st[0] = decay_st(cur.st[0]);
        end
        if (!nxt.st[0][2]) begin
          mask[POS_F0] = 1'b1;
          evt[POS_F0] = contact(item.f0_x, item.f0_y, nxt.st[0][0], item.f0_size[7:1]);
        end

        // finger 1 sees the status left by the jump check
        if (item.f1_ident != 4'd0) begin
          nxt.st[1] = hold_st(nxt.st[1]);
        end else begin
          nxt.st[1] = decay_st(nxt.st[1]);
        end
        if (!nxt.st[1][2]) begin
          mask[POS_F1] = 1'b1;
          evt[POS_F1] = contact(item.f1_x, item.f1_y, nxt.st[1][0], item.f1_size[7:1]);
        end

        mask[POS_SYNC] = 1'b1;
        evt[POS_SYNC] = sync_ev;

        nxt.px = item.f0_x;
        nxt.py = item.f0_y;
        nxt.pw = item.f0_size[7:1];
        nxt.pid = item.f0_ident;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/touch_report_tracker.sv]
// Top level of the touch report tracker: input register, evaluation, event
// batch register and drain. Depends on trt_pkg, trt_in_if, trt_out_if, trt_eval.
//
// Usage:
//   in_ch  : one request beat (touch frame, forced release or key clear).
//   out_ch : event beats (key edge, contact report, frame sync); last marks
//            the final event of a request.
//   cfg_we/cfg_wdata : write jump_threshold; only while the block is idle.
// Path: a beat is first held in the input register; its events are then
// loaded into the batch register, from which the first event is offered.
// Drain: a request holds the batch register until every event it produces
// (1 to 7) is taken; requests that produce no event leave it empty. The
// serial drain of the batch register sets the rate. The next request waits
// in the input register while the current batch drains.
// Reset: tracker state cleared, keys released, jump_threshold = 150, no
// pending request or event.
// Stall: while out_ch.ready is low the current event holds; once the input
// register is also full, in_ch.ready drops.
`default_nettype none

module touch_report_tracker
  import trt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  trt_in_if.sink           in_ch,
  trt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  item_t                 item_r;
  logic                  in_vld_r;
  state_t                state_r;
  state_t                state_nxt;
  logic [15:0]           thr_r;
  logic [NUM_EVT-1:0]    mask_r;
  logic [NUM_EVT-1:0]    mask_nxt;
  evt_t [NUM_EVT-1:0]    evt_r;

  item_t                 in_item;
  evt_t [NUM_EVT-1:0]    eval_evt;
  logic [NUM_EVT-1:0]    eval_mask;
  logic [NUM_EVT-1:0]    low_bit;
  logic [EVT_IDX_W-1:0]  sel;
  logic                  is_last;
  logic                  out_take;
  logic                  in_take;
  logic                  load;

  always_comb begin
    in_item.req_type = in_ch.req_type;
    in_item.key_bits = in_ch.key_bits;
    in_item.f0_x = in_ch.f0_x;
    in_item.f0_y = in_ch.f0_y;
    in_item.f0_size = in_ch.f0_size;
    in_item.f0_ident = in_ch.f0_ident;
    in_item.f1_x = in_ch.f1_x;
    in_item.f1_y = in_ch.f1_y;
    in_item.f1_size = in_ch.f1_size;
    in_item.f1_ident = in_ch.f1_ident;
  end

  trt_eval u_eval (
    .item (item_r),
    .cur  (state_r),
    .thr  (thr_r),
    .nxt  (state_nxt),
    .evt  (eval_evt),
    .mask (eval_mask)
  );

  // lowest pending event drives the output
  always_comb begin
    low_bit = mask_r & (~mask_r + NUM_EVT'(1));
    is_last = (mask_r & ~low_bit) == '0;
    sel = '0;
    for (int i = NUM_EVT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = EVT_IDX_W'(i);
      end
    end
  end

  assign out_take = out_ch.valid && out_ch.ready;
  assign load = in_vld_r && ((mask_r == '0) || (out_take && is_last));
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_vld_r || load;

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = eval_mask;
    end else if (out_take) begin
      mask_nxt = mask_r & ~low_bit;
    end
  end

  assign out_ch.valid = |mask_r;
  assign out_ch.event_kind = evt_r[sel].kind;
  assign out_ch.key_index = evt_r[sel].key_index;
  assign out_ch.key_pressed = evt_r[sel].key_pressed;
  assign out_ch.pos_x = evt_r[sel].pos_x;
  assign out_ch.pos_y = evt_r[sel].pos_y;
  assign out_ch.touch_major = evt_r[sel].touch_major;
  assign out_ch.width = evt_r[sel].width;
  assign out_ch.last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mask_r <= '0;
      state_r <= '0;
      thr_r <= JUMP_THR_RESET;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end
      mask_r <= mask_nxt;
      if (load) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (load) begin
      evt_r <= eval_evt;
    end
  end

endmodule

`default_nettype wire

[tb/tb_touch_report_tracker.sv]
`timescale 1ns / 1ps
// Self-checking bench for touch_report_tracker: directed and random request beats,
// a tracking model in the bench predicts every event beat. Needs trt_pkg, trt_in_if,
// trt_out_if and the block itself.
module tb_touch_report_tracker;
  import trt_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    evt_t ev;
    logic last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  trt_in_if  in_if ();
  trt_out_if out_if ();

  touch_report_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  item_t   request_q[$];
  report_t report_q[$];
  item_t   sent;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      errors = 0;

  logic [15:0] trk_x [2];
  logic [15:0] trk_y [2];
  logic [6:0]  trk_w [2];
  logic [3:0]  trk_id [2];
  status_t     trk_st [2];
  logic [15:0] prev_x;
  logic [15:0] prev_y;
  logic [6:0]  prev_w;
  logic [3:0]  prev_id;
  logic [1:0]  key_lvl;
  logic [15:0] jump_thr;

  // gesture state for well-formed random frames
  logic [15:0] gx [2];
  logic [15:0] gy [2];
  logic [3:0]  gid [2];
  logic [1:0]  gkeys;

  function automatic void add_report(evt_kind_t kind, logic kidx, logic kpr,
                                     logic [15:0] x, logic [15:0] y, logic tm,
                                     logic [6:0] w);
    report_t r;
    r.ev.kind        = kind;
    r.ev.key_index   = kidx;
    r.ev.key_pressed = kpr;
    r.ev.pos_x       = x;
    r.ev.pos_y       = y;
    r.ev.touch_major = tm;
    r.ev.width       = w;
    r.last           = 1'b0;
    report_q.push_back(r);
  endfunction

  function automatic status_t held(status_t s);
    return (s != ST_FORCED) ? ST_PRESSED : ST_FORCED;
  endfunction

  function automatic void track_request(item_t it);
    int          n;
    logic [15:0] dx;
    logic [15:0] dy;
    n = 0;
    case (it.req_type)
      REQ_CLEAR: key_lvl = 2'b00;
      REQ_RELEASE: begin
        for (int i = 0; i < 2; i++) begin
          if (trk_id[i] != 4'd0) trk_st[i] = ST_FORCED;
          if (trk_st[i] == ST_FORCED) begin
            add_report(EV_CONTACT, 1'b0, 1'b0, trk_x[i], trk_y[i], 1'b0, trk_w[i]);
            n++;
          end
        end
        if (n > 0) begin
          add_report(EV_SYNC, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 7'd0);
          report_q[report_q.size() - 1].last = 1'b1;
        end
      end
      REQ_FRAME: begin
        trk_x[0]  = it.f0_x;
        trk_y[0]  = it.f0_y;
        trk_w[0]  = it.f0_size[7:1];
        trk_id[0] = it.f0_ident;
        trk_x[1]  = it.f1_x;
        trk_y[1]  = it.f1_y;
        trk_w[1]  = it.f1_size[7:1];
        trk_id[1] = it.f1_ident;
        // key edges only while no finger is down
        if (trk_st[0] != ST_PRESSED && trk_st[1] != ST_PRESSED) begin
          for (int i = 0; i < 2; i++) begin
            if (it.key_bits[i] != key_lvl[i])
              add_report(EV_KEY, i[0], it.key_bits[i], 16'd0, 16'd0, 1'b0, 7'd0);
            key_lvl[i] = it.key_bits[i];
          end
        end
        for (int i = 0; i < 2; i++) begin
          if (trk_id[i] != 4'd0) begin
            if (i == 0 && trk_st[1] != ST_PRESSED && prev_id != 4'd0) begin
              dx = (prev_x > trk_x[0]) ? prev_x - trk_x[0] : trk_x[0] - prev_x;
              dy = (prev_y > trk_y[0]) ? prev_y - trk_y[0] : trk_y[0] - prev_y;
              if (prev_id != trk_id[0] || dx > jump_thr || dy > jump_thr) begin
                add_report(EV_CONTACT, 1'b0, 1'b0, prev_x, prev_y, 1'b0, prev_w);
                add_report(EV_SYNC, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 7'd0);
                trk_st[1] = ST_IDLE;
              end else begin
                trk_st[0] = held(trk_st[0]);
              end
            end else begin
              trk_st[i] = held(trk_st[i]);
            end
          end else if (trk_st[i] == ST_PRESSED || trk_st[i] == ST_STALE) begin
            trk_st[i] = ST_RELEASED;
          end else if (trk_st[i] == ST_RELEASED || trk_st[i] == ST_FORCED) begin
            trk_st[i] = ST_IDLE;
          end
          if (!trk_st[i][2])
            add_report(EV_CONTACT, 1'b0, 1'b0, trk_x[i], trk_y[i], trk_st[i][0], trk_w[i]);
        end
        add_report(EV_SYNC, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 7'd0);
        report_q[report_q.size() - 1].last = 1'b1;
        prev_x  = trk_x[0];
        prev_y  = trk_y[0];
        prev_w  = trk_w[0];
        prev_id = trk_id[0];
      end
      default: ;
    endcase
  endfunction

  function automatic item_t frame(logic [1:0] kb,
                                  logic [15:0] x0, logic [15:0] y0, logic [7:0] s0,
                                  logic [3:0] id0,
                                  logic [15:0] x1, logic [15:0] y1, logic [7:0] s1,
                                  logic [3:0] id1);
    item_t it;
    it.req_type = REQ_FRAME;
    it.key_bits = kb;
    it.f0_x     = x0;
    it.f0_y     = y0;
    it.f0_size  = s0;
    it.f0_ident = id0;
    it.f1_x     = x1;
    it.f1_y     = y1;
    it.f1_size  = s1;
    it.f1_ident = id1;
    return it;
  endfunction

  function automatic item_t command(logic [1:0] req);
    item_t it;
    it = '0;
    it.req_type = req;
    return it;
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] v);
    int m;
    int d;
    m = $urandom_range(99);
    if (m >= 80) return 16'($urandom);
    if (m < 50) d = int'($urandom_range(20));
    else d = int'(jump_thr) - 1 + int'($urandom_range(2));
    if ($urandom_range(1) == 1) d = -d;
    return v + d[15:0];
  endfunction

  function automatic item_t random_request();
    item_t it;
    int    r;
    if ($urandom_range(99) < 15) begin
      it.req_type = 2'($urandom_range(3));
      it.key_bits = 2'($urandom_range(3));
      it.f0_x     = 16'($urandom);
      it.f0_y     = 16'($urandom);
      it.f0_size  = 8'($urandom);
      it.f0_ident = 4'($urandom);
      it.f1_x     = 16'($urandom);
      it.f1_y     = 16'($urandom);
      it.f1_size  = 8'($urandom);
      it.f1_ident = 4'($urandom);
      return it;
    end
    if ($urandom_range(99) < 30) gkeys = 2'($urandom_range(3));
    for (int f = 0; f < 2; f++) begin
      r = $urandom_range(99);
      if (r < 12) gid[f] = 4'd0;
      else if (r < 22 || (gid[f] == 4'd0 && r < 60)) gid[f] = 4'($urandom_range(1, 15));
      gx[f] = nudge(gx[f]);
      gy[f] = nudge(gy[f]);
    end
    it = frame(gkeys, gx[0], gy[0], 8'($urandom), gid[0],
               gx[1], gy[1], 8'($urandom), gid[1]);
    r = $urandom_range(99);
    if (r < 6) it.req_type = REQ_RELEASE;
    else if (r < 10) it.req_type = REQ_CLEAR;
    else if (r < 12) it.req_type = REQ_UNUSED;
    return it;
  endfunction

  task automatic queue_random(int count);
    repeat (count) request_q.push_back(random_request());
  endtask

  task automatic settle();
    while (request_q.size() != 0 || in_if.valid || report_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    jump_thr = v;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) track_request(sent);
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sent = request_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.req_type <= sent.req_type;
          in_if.key_bits <= sent.key_bits;
          in_if.f0_x     <= sent.f0_x;
          in_if.f0_y     <= sent.f0_y;
          in_if.f0_size  <= sent.f0_size;
          in_if.f0_ident <= sent.f0_ident;
          in_if.f1_x     <= sent.f1_x;
          in_if.f1_y     <= sent.f1_y;
          in_if.f1_size  <= sent.f1_size;
          in_if.f1_ident <= sent.f1_ident;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (report_q.size() == 0) begin
          $error("event beat with nothing pending, kind %0d", out_if.event_kind);
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("event_kind", want.ev.kind, out_if.event_kind);
          check_field("key_index", want.ev.key_index, out_if.key_index);
          check_field("key_pressed", want.ev.key_pressed, out_if.key_pressed);
          check_field("pos_x", want.ev.pos_x, out_if.pos_x);
          check_field("pos_y", want.ev.pos_y, out_if.pos_y);
          check_field("touch_major", want.ev.touch_major, out_if.touch_major);
          check_field("width", want.ev.width, out_if.width);
          check_field("last", want.last, out_if.last);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 16'd0;
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_FRAME;
    in_if.key_bits = 2'd0;
    in_if.f0_x     = 16'd0;
    in_if.f0_y     = 16'd0;
    in_if.f0_size  = 8'd0;
    in_if.f0_ident = 4'd0;
    in_if.f1_x     = 16'd0;
    in_if.f1_y     = 16'd0;
    in_if.f1_size  = 8'd0;
    in_if.f1_ident = 4'd0;
    out_if.ready   = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trk_x[i]  = 16'd0;
      trk_y[i]  = 16'd0;
      trk_w[i]  = 7'd0;
      trk_id[i] = 4'd0;
      trk_st[i] = ST_RELEASED;
      gx[i]     = 16'd0;
      gy[i]     = 16'd0;
      gid[i]    = 4'd0;
    end
    prev_x   = 16'd0;
    prev_y   = 16'd0;
    prev_w   = 7'd0;
    prev_id  = 4'd0;
    key_lvl  = 2'b00;
    jump_thr = JUMP_THR_RESET;
    gkeys    = 2'b00;
    send_idle_pct = 13;
    recv_idle_pct = 86;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, threshold at its reset value
    request_q.push_back(frame(2'd3, 16'd0, 16'd0, 8'd0, 4'd0, 16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd3, 16'd100, 16'd100, 8'd255, 4'd1,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd250, 16'd100, 8'd254, 4'd1,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd401, 16'd100, 8'd1, 4'd1,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd401, 16'hffff, 8'd1, 4'd1,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd401, 16'hffff, 8'd1, 4'd15,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd1, 16'd401, 16'hffff, 8'd1, 4'd15,
                              16'hffff, 16'd0, 8'd0, 4'd3));
    request_q.push_back(frame(2'd2, 16'd0, 16'd0, 8'd128, 4'd15,
                              16'hffff, 16'hffff, 8'd255, 4'd15));
    request_q.push_back(command(REQ_RELEASE));
    request_q.push_back(frame(2'd2, 16'd5, 16'd5, 8'd5, 4'd15, 16'd7, 16'd7, 8'd7, 4'd3));
    request_q.push_back(frame(2'd0, 16'd5, 16'd5, 8'd5, 4'd0, 16'd7, 16'd7, 8'd7, 4'd0));
    request_q.push_back(command(REQ_RELEASE));
    request_q.push_back(command(REQ_CLEAR));
    request_q.push_back(command(REQ_UNUSED));
    request_q.push_back(frame(2'd3, 16'd1000, 16'd1000, 8'd3, 4'd2,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd3, 16'd1000, 16'd1000, 8'd3, 4'd0,
                              16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd0, 16'd0, 8'd0, 4'd0, 16'd0, 16'd0, 8'd0, 4'd0));
    request_q.push_back(frame(2'd0, 16'd0, 16'd0, 8'd0, 4'd0,
                              16'd300, 16'd300, 8'd9, 4'd4));
    request_q.push_back(frame(2'd0, 16'hffff, 16'hffff, 8'd255, 4'd9,
                              16'd300, 16'd300, 8'd9, 4'd4));
    request_q.push_back(frame(2'd0, 16'd0, 16'd0, 8'd0, 4'd0, 16'd0, 16'd0, 8'd0, 4'd0));
    settle();

    write_threshold(16'hffff);
    queue_random(30);
    settle();

    send_idle_pct = 86;
    recv_idle_pct = 13;
    write_threshold(16'h0000);
    queue_random(15);
    settle();
    queue_random(15);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(16'($urandom_range(100, 400)));
    queue_random(30);
    settle();

    if (errors == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
